[hdl/mtf_pkg.sv]
`timescale 1ns / 1ps

package mtf_pkg;

    localparam int SYM_W    = 8;
    localparam int GRP_SIZE = 16;
    localparam int GRP_W    = 4;

    typedef logic [SYM_W-1:0] t_sym;

    typedef struct packed {
        logic load_id;
        logic capture;
        logic shift;
        t_sym sym;
        t_sym pos;
    } t_cell_ctl;

endpackage

[hdl/mtf_cell.sv]
`timescale 1ns / 1ps

module mtf_cell #(
    parameter int INDEX = 0
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mtf_pkg::t_cell_ctl i_ctl,
    input  mtf_pkg::t_sym     i_left,
    output mtf_pkg::t_sym     o_value,
    output logic              o_match
);
    import mtf_pkg::*;

    localparam t_sym C_IDX = t_sym'(INDEX);

    t_sym r_value;
    logic r_match;
    t_sym w_cur;

    assign w_cur = i_ctl.load_id ? C_IDX : r_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value <= C_IDX;
            r_match <= 1'b0;
        end else if (i_ctl.capture) begin
            r_value <= w_cur;
            r_match <= (w_cur == i_ctl.sym);
        end else if (i_ctl.shift) begin
            if (C_IDX <= i_ctl.pos) begin
                r_value <= i_left;
            end
            r_match <= 1'b0;
        end
    end

    assign o_value = r_value;
    assign o_match = r_match;

endmodule

[hdl/mtf_rank_enc.sv]
`timescale 1ns / 1ps

module mtf_rank_enc #(
    parameter int NUM_CELLS = 256
) (
    input  logic                 i_clk,
    input  logic [NUM_CELLS-1:0] i_match,
    output mtf_pkg::t_sym        o_pos,
    output logic                 o_found
);
    import mtf_pkg::*;

    localparam int NUM_GRP = (NUM_CELLS + GRP_SIZE - 1) / GRP_SIZE;
    localparam int PAD_W   = NUM_GRP * GRP_SIZE;

    logic [PAD_W-1:0]     w_match;
    logic [NUM_GRP-1:0]   n_any;
    logic [GRP_W-1:0]     n_lo [NUM_GRP];
    logic [NUM_GRP-1:0]   r_any;
    logic [GRP_W-1:0]     r_lo [NUM_GRP];
    logic [GRP_W-1:0]     w_hi;
    logic [GRP_W-1:0]     w_lo;

    assign w_match = PAD_W'(i_match);

    always_comb begin
        for (int g = 0; g < NUM_GRP; g++) begin
            n_any[g] = |w_match[g*GRP_SIZE +: GRP_SIZE];
            n_lo[g]  = '0;
            for (int j = 0; j < GRP_SIZE; j++) begin
                if (w_match[g*GRP_SIZE + j]) begin
                    n_lo[g] = n_lo[g] | GRP_W'(j);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_any <= n_any;
        for (int g = 0; g < NUM_GRP; g++) begin
            r_lo[g] <= n_lo[g];
        end
    end

    always_comb begin
        w_hi = '0;
        w_lo = '0;
        for (int g = 0; g < NUM_GRP; g++) begin
            if (r_any[g]) begin
                w_hi = w_hi | GRP_W'(g);
            end
            w_lo = w_lo | r_lo[g];
        end
    end

    assign o_pos   = {w_hi, w_lo};
    assign o_found = |r_any;

endmodule

[hdl/move_to_front_encoder.sv]
`timescale 1ns / 1ps
// Move-to-front byte encoder.
// Input channel: i_valid / o_ready carry i_symbol and i_block_start; a transfer
// takes place when both are high. Output channel: o_valid / i_ready carry o_rank,
// the position of the symbol in the recency list before it moves to the front.
// i_block_start restores identity order before the symbol is looked up.
// The list lives in a row of ALPHABET_SIZE cells; each cell compares its entry
// with the symbol in parallel and, on update, takes its left neighbor's entry
// when its position is at or below the rank.
// o_valid rises after the match flags, the rank encoder and the output register
// are loaded in turn. Each byte passes compare, rank encode (a registered
// one-hot-to-index encoder) and shift before the next byte is taken.
// The output register holds one result; o_ready rises again as soon as that
// result is written, so a new byte is taken while the result waits.
// When the receiver stalls, the shift waits until the output register is free.
// Reset (synchronous, active low) puts the list in identity order and empties
// the output register; no clearing pass is needed.
module move_to_front_encoder #(
    parameter int ALPHABET_SIZE = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  mtf_pkg::t_sym     i_symbol,
    input  logic              i_block_start,
    output logic              o_valid,
    input  logic              i_ready,
    output mtf_pkg::t_sym     o_rank
);
    import mtf_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_GRP  = 2'd1;
    localparam logic [1:0] S_UPD  = 2'd2;

    logic [1:0]               r_state;
    logic [1:0]               n_state;
    t_sym                     r_sym;
    logic                     r_out_valid;
    t_sym                     r_rank;
    t_cell_ctl                w_ctl;
    t_sym                     w_value [ALPHABET_SIZE];
    logic [ALPHABET_SIZE-1:0] w_match;
    t_sym                     w_pos;
    logic                     w_found;
    logic                     w_accept;
    logic                     w_slot_free;
    logic                     w_done;
    logic                     w_update;

    assign o_ready     = (r_state == S_IDLE);
    assign w_accept    = i_valid && o_ready;
    assign w_slot_free = !r_out_valid || i_ready;
    assign w_done      = (r_state == S_UPD) && w_slot_free;
    assign w_update    = w_done && w_found;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (w_accept) n_state = S_GRP;
            S_GRP:   n_state = S_UPD;
            S_UPD:   if (w_slot_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_done) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_sym <= i_symbol;
        end
        if (w_done) begin
            r_rank <= w_found ? w_pos : '0;
        end
    end

    assign w_ctl.load_id = w_accept && i_block_start;
    assign w_ctl.capture = w_accept;
    assign w_ctl.shift   = w_update;
    assign w_ctl.sym     = (r_state == S_IDLE) ? i_symbol : r_sym;
    assign w_ctl.pos     = w_pos;

    for (genvar i = 0; i < ALPHABET_SIZE; i++) begin : g_cell
        mtf_cell #(
            .INDEX (i)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_left  ((i == 0) ? r_sym : w_value[(i == 0) ? 0 : i - 1]),
            .o_value (w_value[i]),
            .o_match (w_match[i])
        );
    end

    mtf_rank_enc #(
        .NUM_CELLS (ALPHABET_SIZE)
    ) u_rank_enc (
        .i_clk   (i_clk),
        .i_match (w_match),
        .o_pos   (w_pos),
        .o_found (w_found)
    );

    assign o_valid = r_out_valid;
    assign o_rank  = r_rank;

    a_match_onehot0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_match))
        else $error("more than one cell matches the symbol");

    a_front_after_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_update |=> (w_value[0] == $past(r_sym)))
        else $error("front cell does not hold the coded symbol");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_ready ##1 !o_ready)
        else $error("input taken while the previous byte is in flight");

    a_result_written: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |=> (o_valid && (r_state == S_IDLE)))
        else $error("result not presented after update");

endmodule
